// File: rtl/single_wire_sensor_frame_reader_unit_macros.svh
// ----------------------------------------------------------------------------
// single-wire sensor frame reader: assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_SENSOR_FRAME_READER_UNIT_MACROS_SVH
`define SINGLE_WIRE_SENSOR_FRAME_READER_UNIT_MACROS_SVH

// same-cycle implication
`define SWFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swfr check failed");

// next-cycle implication
`define SWFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swfr check failed");

`endif

// File: rtl/swfr_pkg.sv
// ----------------------------------------------------------------------------
// swfr_pkg
// types and constants shared by the sensor frame reader modules
// ----------------------------------------------------------------------------
`default_nettype none

package swfr_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int FRAME_BITS  = 40;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SENSOR_TYPE      = 3'd0,
      CSR_START_LOW_TICKS  = 3'd1,
      CSR_RELEASE_TICKS    = 3'd2,
      CSR_RESPONSE_LIMIT   = 3'd3,
      CSR_BIT_WAIT_LIMIT   = 3'd4,
      CSR_BIT_SAMPLE_DELAY = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK             = 3'd0,
      STATUS_NO_RESPONSE    = 3'd1,
      STATUS_RESP_LOW_TOUT  = 3'd2,
      STATUS_RESP_HIGH_TOUT = 3'd3,
      STATUS_BIT_TOUT       = 3'd4,
      STATUS_CHECKSUM_BAD   = 3'd5
   } status_type;

   typedef struct packed {
      logic       sensor_type;
      logic [15:0] start_low_ticks;
      logic [7:0] release_ticks;
      logic [7:0] response_limit;
      logic [7:0] bit_wait_limit;
      logic [7:0] bit_sample_delay;
   } cfg_type;

   // classified item passed from front to back
   typedef struct packed {
      logic is_start;
      logic pin_level;
   } item_type;

   // result item, drive_low in the lowest bit
   typedef struct packed {
      logic [1:0]  pad;
      logic [15:0] temperature;
      logic [15:0] humidity;
      status_type  status;
      logic        done_res;
      logic        busy_res;
      logic        drive_low;
   } rsp_fields_type;

endpackage

`default_nettype wire

// File: rtl/single_wire_sensor_frame_reader_unit.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_reader_unit
// reads one frame from a single-wire temperature and humidity sensor
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side keeps taking results: each
// item is a one-microsecond line sample or a start request, and each gives
// exactly one result item. An input register and a four-entry queue sit in
// front of the read sequencer, whose output register holds the result until
// it is taken; an accepted item passes through the input register and a queue
// entry into the output register. The sequencer handles one item per cycle, so
// throughput is set only by the result side taking items.
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_sensor_frame_reader_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [swfr_pkg::REQ_TDATA_W-1:0]   req_tdata, // pin_level, zero pad
   input  wire logic                               req_tuser, // action
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // drive_low, busy_res, done_res, status[2:0], humidity[15:0],
   // temperature[15:0], zero pad
   output logic [swfr_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [swfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [swfr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   swfr_pkg::cfg_type  cfg_ff;
   logic               push_valid;
   logic               push_ready;
   swfr_pkg::item_type push_item;
   logic               pop_valid;
   logic               pop_ready;
   swfr_pkg::item_type pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_type      <= 1'b0;
         cfg_ff.start_low_ticks  <= 16'd20000;
         cfg_ff.release_ticks    <= 8'd20;
         cfg_ff.response_limit   <= 8'd90;
         cfg_ff.bit_wait_limit   <= 8'd60;
         cfg_ff.bit_sample_delay <= 8'd30;
      end else if (csr_we) begin
         case (csr_index)
            swfr_pkg::CSR_SENSOR_TYPE:      cfg_ff.sensor_type      <= csr_wdata[0];
            swfr_pkg::CSR_START_LOW_TICKS:  cfg_ff.start_low_ticks  <= csr_wdata;
            swfr_pkg::CSR_RELEASE_TICKS:    cfg_ff.release_ticks    <= csr_wdata[7:0];
            swfr_pkg::CSR_RESPONSE_LIMIT:   cfg_ff.response_limit   <= csr_wdata[7:0];
            swfr_pkg::CSR_BIT_WAIT_LIMIT:   cfg_ff.bit_wait_limit   <= csr_wdata[7:0];
            swfr_pkg::CSR_BIT_SAMPLE_DELAY: cfg_ff.bit_sample_delay <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   swfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   swfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   swfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: rtl/swfr_front.sv
// ----------------------------------------------------------------------------
// swfr_front
// input stage: takes request items and classifies them as start or tick
// ----------------------------------------------------------------------------
`default_nettype none

module swfr_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [swfr_pkg::REQ_TDATA_W-1:0] req_tdata, // pin_level, zero pad
   input  wire logic                           req_tuser, // action
   output logic                                push_valid,
   output swfr_pkg::item_type                  push_item,
   input  wire logic                           push_ready
);

   logic               valid_ff;
   swfr_pkg::item_type item_ff;
   swfr_pkg::item_type item_in;

   assign req_tready = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      item_in.is_start  = req_tuser;
      item_in.pin_level = req_tdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         valid_ff <= 1'b1;
      end else if (push_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/swfr_queue.sv
// ----------------------------------------------------------------------------
// swfr_queue
// short fifo between the front stage and the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module swfr_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire swfr_pkg::item_type push_item,
   output logic                    push_ready,
   output logic                    pop_valid,
   output swfr_pkg::item_type      pop_item,
   input  wire logic               pop_ready
);

   swfr_pkg::item_type                   mem_ff [swfr_pkg::QUEUE_DEPTH];
   logic [swfr_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [swfr_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [swfr_pkg::QUEUE_CNT_W-1:0]     count_ff;
   logic                                 do_push;
   logic                                 do_pop;

   assign push_ready = (count_ff != swfr_pkg::QUEUE_CNT_W'(swfr_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/swfr_back.sv
// ----------------------------------------------------------------------------
// swfr_back
// read sequencer: times the start pulse, response and data bits, checks
// the frame and registers one result item per input item
// ----------------------------------------------------------------------------
`default_nettype none

module swfr_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire swfr_pkg::cfg_type                cfg,
   input  wire logic                             pop_valid,
   input  wire swfr_pkg::item_type               pop_item,
   output logic                                  pop_ready,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [swfr_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START_LOW,
      PH_RELEASE,
      PH_RESP_LOW,
      PH_RESP_HIGH,
      PH_BIT_LOW,
      PH_BIT_DELAY,
      PH_BIT_HIGH
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [15:0]               tick_count_ff, tick_count_in;
   logic [5:0]                bit_index_ff, bit_index_in;
   logic [39:0]               frame_bits_ff, frame_bits_in;
   swfr_pkg::status_type      status_ff, status_in;
   logic [15:0]               humidity_ff, humidity_in;
   logic [15:0]               temperature_ff, temperature_in;
   logic                      rsp_valid_ff;
   swfr_pkg::rsp_fields_type  rsp_ff, rsp_in;

   logic                      pop;
   logic                      done;
   logic [15:0]               tick_inc;
   logic [5:0]                bit_inc;
   logic [7:0]                byte_sum;
   logic                      sum_ok;

   function automatic logic [15:0] join_value(input logic kind, input logic [7:0] hi,
                                              input logic [7:0] lo);
      logic [15:0] hi_w;
      hi_w = {8'd0, hi};
      if (!kind) begin
         // hi * 10 as two shifts
         join_value = (hi_w << 3) + (hi_w << 1) + {8'd0, lo};
      end else begin
         join_value = {hi, lo};
      end
   endfunction

   assign pop        = pop_valid && (!rsp_valid_ff || rsp_tready);
   assign pop_ready  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assign tick_inc = tick_count_ff + 16'd1;
   assign bit_inc  = bit_index_ff + 6'd1;
   assign byte_sum = frame_bits_ff[39:32] + frame_bits_ff[31:24]
                   + frame_bits_ff[23:16] + frame_bits_ff[15:8];
   assign sum_ok   = (byte_sum == frame_bits_ff[7:0]);

   always_comb begin
      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      bit_index_in   = bit_index_ff;
      frame_bits_in  = frame_bits_ff;
      status_in      = status_ff;
      humidity_in    = humidity_ff;
      temperature_in = temperature_ff;
      done           = 1'b0;

      if (pop_item.is_start) begin
         // a start while a read runs is dropped
         if (phase_ff == PH_IDLE) begin
            phase_in      = PH_START_LOW;
            tick_count_in = '0;
            bit_index_in  = '0;
            frame_bits_in = '0;
         end
      end else if (phase_ff != PH_IDLE) begin
         case (phase_ff)
            PH_START_LOW: begin
               tick_count_in = tick_inc;
               if (tick_inc >= cfg.start_low_ticks) begin
                  phase_in      = PH_RELEASE;
                  tick_count_in = '0;
               end
            end
            PH_RELEASE: begin
               tick_count_in = tick_inc;
               if (tick_inc >= {8'd0, cfg.release_ticks}) begin
                  tick_count_in = '0;
                  if (pop_item.pin_level) begin
                     phase_in  = PH_IDLE;
                     status_in = swfr_pkg::STATUS_NO_RESPONSE;
                  end else begin
                     phase_in = PH_RESP_LOW;
                  end
               end
            end
            PH_RESP_LOW: begin
               if (pop_item.pin_level) begin
                  phase_in      = PH_RESP_HIGH;
                  tick_count_in = '0;
               end else begin
                  tick_count_in = tick_inc;
                  if (tick_inc > {8'd0, cfg.response_limit}) begin
                     phase_in      = PH_IDLE;
                     tick_count_in = '0;
                     status_in     = swfr_pkg::STATUS_RESP_LOW_TOUT;
                  end
               end
            end
            PH_RESP_HIGH: begin
               if (!pop_item.pin_level) begin
                  phase_in      = PH_BIT_LOW;
                  tick_count_in = '0;
               end else begin
                  tick_count_in = tick_inc;
                  if (tick_inc > {8'd0, cfg.response_limit}) begin
                     phase_in      = PH_IDLE;
                     tick_count_in = '0;
                     status_in     = swfr_pkg::STATUS_RESP_HIGH_TOUT;
                  end
               end
            end
            PH_BIT_LOW: begin
               if (pop_item.pin_level) begin
                  phase_in      = PH_BIT_DELAY;
                  tick_count_in = '0;
               end else begin
                  tick_count_in = tick_inc;
                  if (tick_inc >= {8'd0, cfg.bit_wait_limit}) begin
                     phase_in      = PH_IDLE;
                     tick_count_in = '0;
                     status_in     = swfr_pkg::STATUS_BIT_TOUT;
                  end
               end
            end
            PH_BIT_DELAY: begin
               tick_count_in = tick_inc;
               if (tick_inc >= {8'd0, cfg.bit_sample_delay}) begin
                  frame_bits_in = {frame_bits_ff[38:0], pop_item.pin_level};
                  phase_in      = PH_BIT_HIGH;
                  tick_count_in = '0;
               end
            end
            PH_BIT_HIGH: begin
               if (!pop_item.pin_level) begin
                  bit_index_in  = bit_inc;
                  tick_count_in = '0;
                  if (bit_inc >= 6'(swfr_pkg::FRAME_BITS)) begin
                     phase_in = PH_IDLE;
                     if (sum_ok) begin
                        status_in      = swfr_pkg::STATUS_OK;
                        humidity_in    = join_value(cfg.sensor_type, frame_bits_ff[39:32],
                                                    frame_bits_ff[31:24]);
                        temperature_in = join_value(cfg.sensor_type, frame_bits_ff[23:16],
                                                    frame_bits_ff[15:8]);
                     end else begin
                        status_in = swfr_pkg::STATUS_CHECKSUM_BAD;
                     end
                  end else begin
                     phase_in = PH_BIT_LOW;
                  end
               end else begin
                  tick_count_in = tick_inc;
                  if (tick_inc >= {8'd0, cfg.bit_wait_limit}) begin
                     phase_in      = PH_IDLE;
                     tick_count_in = '0;
                     status_in     = swfr_pkg::STATUS_BIT_TOUT;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         done = (phase_in == PH_IDLE);
      end

      rsp_in.pad         = '0;
      rsp_in.temperature = temperature_in;
      rsp_in.humidity    = humidity_in;
      rsp_in.status      = status_in;
      rsp_in.done_res    = done;
      rsp_in.busy_res    = (phase_in != PH_IDLE);
      rsp_in.drive_low   = (phase_in == PH_START_LOW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tick_count_ff  <= '0;
         bit_index_ff   <= '0;
         frame_bits_ff  <= '0;
         status_ff      <= swfr_pkg::STATUS_OK;
         humidity_ff    <= '0;
         temperature_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff       <= phase_in;
            tick_count_ff  <= tick_count_in;
            bit_index_ff   <= bit_index_in;
            frame_bits_ff  <= frame_bits_in;
            status_ff      <= status_in;
            humidity_ff    <= humidity_in;
            temperature_ff <= temperature_in;
            rsp_valid_ff   <= 1'b1;
            rsp_ff         <= rsp_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/swfr_checker.sv
// ----------------------------------------------------------------------------
// swfr_checker
// port-level checks on the result channel of the frame reader
// ----------------------------------------------------------------------------
`default_nettype none

`include "single_wire_sensor_frame_reader_unit_macros.svh"

module swfr_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [swfr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic       rsp_stall;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic [2:0] rsp_status;
   logic       status_known;

   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign drive_low    = rsp_tdata[0];
   assign busy_res     = rsp_tdata[1];
   assign done_res     = rsp_tdata[2];
   assign rsp_status   = rsp_tdata[5:3];
   assign status_known = (rsp_status <= 3'(swfr_pkg::STATUS_CHECKSUM_BAD));

   // a stalled result holds
   `SWFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // nothing left over from before reset
   `SWFR_ASSERT_NOW(a_rsp_empty_after_reset, clock, reset, $past(reset), !rsp_tvalid)

   // the line is only pulled low inside a read
   `SWFR_ASSERT_NOW(a_drive_in_read, clock, reset, rsp_tvalid && drive_low, busy_res)

   // a finished read is no longer busy and carries a known status
   `SWFR_ASSERT_NOW(a_done_status, clock, reset, rsp_tvalid && done_res, !busy_res && status_known)

endmodule

bind single_wire_sensor_frame_reader_unit swfr_checker u_swfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: sim/tb_single_wire_sensor_frame_reader_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_single_wire_sensor_frame_reader_unit
// self-checking bench for the single-wire sensor frame reader
// ----------------------------------------------------------------------------
// Plays sensor line waveforms into the block one tick per item: whole frames
// with random bytes, broken responses, bit timeouts, bad checksums and start
// requests while busy. A behavioural copy of the read sequencer predicts each
// result item, and the monitor compares every accepted result with the oldest
// prediction. Both stream sides idle at random; the receiver also stalls for a
// long stretch so that the block backs up. Settings are swept between phases,
// including all-zero, minimum and the widest 8-bit count registers.
// ----------------------------------------------------------------------------

module tb_single_wire_sensor_frame_reader_unit;

   typedef enum logic [3:0] {
      RD_IDLE,
      RD_START_LOW,
      RD_RELEASE,
      RD_RESP_LOW,
      RD_RESP_HIGH,
      RD_BIT_LOW,
      RD_BIT_DELAY,
      RD_BIT_HIGH
   } read_phase_type;

   typedef enum int {
      FAULT_NONE,
      FAULT_NO_RESPONSE,
      FAULT_RESP_LOW,
      FAULT_RESP_HIGH,
      FAULT_BIT_LOW,
      FAULT_BIT_HIGH,
      FAULT_CHECKSUM
   } fault_type;

   localparam logic [swfr_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [swfr_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam int STALL_CYCLES = 400;
   localparam int SETTLE_CYCLES = 10;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [swfr_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [swfr_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_we = 1'b0;
   logic [swfr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [swfr_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   single_wire_sensor_frame_reader_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor state and its copy of the registers
   swfr_pkg::cfg_type    cfg;
   read_phase_type       rd_phase;
   logic [15:0]          tick_cnt;
   logic [5:0]           bit_cnt;
   logic [39:0]          frame_shift;
   swfr_pkg::status_type status_latched;
   logic [15:0]          hum_val;
   logic [15:0]          temp_val;

   swfr_pkg::item_type       line_samples[$];
   swfr_pkg::rsp_fields_type expected_readings[$];
   int             mismatches = 0;
   bit             idling_on = 1'b1;
   bit             in_read = 1'b0;
   logic           stall_active = 1'b0;
   event           stall_kick;
   int             send_wait = 0;
   int             take_wait = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   task automatic enter_phase(read_phase_type p);
      rd_phase = p;
      tick_cnt = '0;
   endtask

   task automatic end_read(swfr_pkg::status_type code);
      rd_phase = RD_IDLE;
      tick_cnt = '0;
      status_latched = code;
   endtask

   function automatic logic [15:0] join_bytes(logic [7:0] hi, logic [7:0] lo);
      if (cfg.sensor_type == 1'b0)
         return {8'd0, hi} * 16'd10 + {8'd0, lo};
      return {hi, lo};
   endfunction

   task automatic advance_reader(input logic is_start, input logic pin,
                                 output swfr_pkg::rsp_fields_type res);
      logic       finished;
      logic [7:0] byte_sum;
      finished = 1'b0;
      if (is_start) begin
         // a start while busy is dropped without counting as a tick
         if (rd_phase == RD_IDLE) begin
            enter_phase(RD_START_LOW);
            bit_cnt = '0;
            frame_shift = '0;
         end
      end else if (rd_phase != RD_IDLE) begin
         case (rd_phase)
            RD_START_LOW: begin
               tick_cnt = tick_cnt + 1'b1;
               if (tick_cnt >= cfg.start_low_ticks)
                  enter_phase(RD_RELEASE);
            end
            RD_RELEASE: begin
               tick_cnt = tick_cnt + 1'b1;
               if (tick_cnt >= cfg.release_ticks) begin
                  if (pin)
                     end_read(swfr_pkg::STATUS_NO_RESPONSE);
                  else
                     enter_phase(RD_RESP_LOW);
               end
            end
            RD_RESP_LOW: begin
               if (pin) begin
                  enter_phase(RD_RESP_HIGH);
               end else begin
                  tick_cnt = tick_cnt + 1'b1;
                  if (tick_cnt > cfg.response_limit)
                     end_read(swfr_pkg::STATUS_RESP_LOW_TOUT);
               end
            end
            RD_RESP_HIGH: begin
               if (!pin) begin
                  enter_phase(RD_BIT_LOW);
               end else begin
                  tick_cnt = tick_cnt + 1'b1;
                  if (tick_cnt > cfg.response_limit)
                     end_read(swfr_pkg::STATUS_RESP_HIGH_TOUT);
               end
            end
            RD_BIT_LOW: begin
               if (pin) begin
                  enter_phase(RD_BIT_DELAY);
               end else begin
                  tick_cnt = tick_cnt + 1'b1;
                  if (tick_cnt >= cfg.bit_wait_limit)
                     end_read(swfr_pkg::STATUS_BIT_TOUT);
               end
            end
            RD_BIT_DELAY: begin
               tick_cnt = tick_cnt + 1'b1;
               if (tick_cnt >= cfg.bit_sample_delay) begin
                  frame_shift = {frame_shift[38:0], pin};
                  enter_phase(RD_BIT_HIGH);
               end
            end
            RD_BIT_HIGH: begin
               if (!pin) begin
                  bit_cnt = bit_cnt + 1'b1;
                  if (bit_cnt >= swfr_pkg::FRAME_BITS) begin
                     byte_sum = frame_shift[39:32] + frame_shift[31:24]
                              + frame_shift[23:16] + frame_shift[15:8];
                     if (byte_sum == frame_shift[7:0]) begin
                        hum_val = join_bytes(frame_shift[39:32], frame_shift[31:24]);
                        temp_val = join_bytes(frame_shift[23:16], frame_shift[15:8]);
                        end_read(swfr_pkg::STATUS_OK);
                     end else begin
                        end_read(swfr_pkg::STATUS_CHECKSUM_BAD);
                     end
                  end else begin
                     enter_phase(RD_BIT_LOW);
                  end
               end else begin
                  tick_cnt = tick_cnt + 1'b1;
                  if (tick_cnt >= cfg.bit_wait_limit)
                     end_read(swfr_pkg::STATUS_BIT_TOUT);
               end
            end
            default: rd_phase = RD_IDLE;
         endcase
         finished = (rd_phase == RD_IDLE);
      end
      res.pad = '0;
      res.drive_low = (rd_phase == RD_START_LOW);
      res.busy_res = (rd_phase != RD_IDLE);
      res.done_res = finished;
      res.status = status_latched;
      res.humidity = hum_val;
      res.temperature = temp_val;
   endtask

   // ------------------------------------------------------------ sender side

   always @(posedge clock) begin
      swfr_pkg::item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_wait != 0) begin
            req_tvalid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (line_samples.size() != 0) begin
            nxt = line_samples.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= swfr_pkg::REQ_TDATA_W'(nxt.pin_level);
            req_tuser <= nxt.is_start;
            send_wait <= idling_on ? $urandom_range(0, 15) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      swfr_pkg::rsp_fields_type predicted;
      if (!reset && req_tvalid && req_tready) begin
         advance_reader(req_tuser, req_tdata[0], predicted);
         expected_readings.push_back(predicted);
      end
   end

   // ---------------------------------------------------------- receiver side

   always @(posedge clock) begin
      swfr_pkg::rsp_fields_type seen;
      swfr_pkg::rsp_fields_type want;
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_wait <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         seen = swfr_pkg::rsp_fields_type'(rsp_tdata);
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item %h", rsp_tdata);
         end else begin
            want = expected_readings.pop_front();
            if (seen.drive_low !== want.drive_low || seen.busy_res !== want.busy_res ||
                seen.done_res !== want.done_res || seen.status !== want.status ||
                seen.humidity !== want.humidity || seen.temperature !== want.temperature) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %b%b%b st=%0d h=%0d t=%0d got %b%b%b st=%0d h=%0d t=%0d",
                           want.drive_low, want.busy_res, want.done_res, want.status,
                           want.humidity, want.temperature,
                           seen.drive_low, seen.busy_res, seen.done_res, seen.status,
                           seen.humidity, seen.temperature);
            end
         end
         gap = idling_on ? $urandom_range(0, 15) : 0;
         take_wait <= gap;
         rsp_tready <= (gap == 0) && !stall_active;
      end else if (take_wait != 0) begin
         take_wait <= take_wait - 1;
         rsp_tready <= (take_wait == 1) && !stall_active;
      end else begin
         rsp_tready <= !stall_active;
      end
   end

   // long receiver hold-off so the input queue fills and back-pressures
   initial begin
      forever begin
         @(stall_kick);
         @(posedge clock);
         stall_active <= 1'b1;
         repeat (STALL_CYCLES) @(posedge clock);
         stall_active <= 1'b0;
      end
   end

   // --------------------------------------------------------------- stimulus

   function automatic int at_least_one(int v);
      return (v == 0) ? 1 : v;
   endfunction

   // mostly short phases, now and then the longest legal one
   function automatic int pick_len(int longest);
      if (longest <= 0)
         return 0;
      if ($urandom_range(0, 7) == 0)
         return longest;
      return $urandom_range(0, (longest < 3) ? longest : 3);
   endfunction

   task automatic push_item(logic is_start, logic level);
      swfr_pkg::item_type it;
      it.is_start = is_start;
      it.pin_level = level;
      line_samples.push_back(it);
   endtask

   task automatic push_tick(logic level);
      // sprinkle start requests into a read in progress; the block must drop them
      if (in_read && $urandom_range(0, 31) == 0)
         push_item(1'b1, 1'($urandom_range(0, 1)));
      push_item(1'b0, level);
   endtask

   task automatic push_ticks(int n, logic level);
      repeat (n) push_tick(level);
   endtask

   task automatic push_noise(int n);
      repeat (n) push_tick(1'($urandom_range(0, 1)));
   endtask

   // one sensor answer, cut short at the chosen fault
   task automatic play_read(fault_type fault);
      logic [7:0]  bytes_in [4];
      logic [7:0]  check_byte;
      logic [39:0] frame;
      int          fault_bit;
      int          wait_cap;
      int          sample_cap;
      wait_cap = at_least_one(cfg.bit_wait_limit);
      sample_cap = at_least_one(cfg.bit_sample_delay);
      push_item(1'b1, 1'($urandom_range(0, 1)));
      in_read = 1'b1;
      push_noise(at_least_one(cfg.start_low_ticks));
      push_noise(at_least_one(cfg.release_ticks) - 1);
      push_tick(fault == FAULT_NO_RESPONSE);
      if (fault == FAULT_NO_RESPONSE)
         return;
      if (fault == FAULT_RESP_LOW) begin
         push_ticks(cfg.response_limit + 1, 1'b0);
         return;
      end
      push_ticks(pick_len(cfg.response_limit), 1'b0);
      push_tick(1'b1);
      if (fault == FAULT_RESP_HIGH) begin
         push_ticks(cfg.response_limit + 1, 1'b1);
         return;
      end
      push_ticks(pick_len(cfg.response_limit), 1'b1);
      push_tick(1'b0);
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(0, 3) == 0)
            bytes_in[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else
            bytes_in[i] = 8'($urandom);
      end
      check_byte = bytes_in[0] + bytes_in[1] + bytes_in[2] + bytes_in[3];
      if (fault == FAULT_CHECKSUM)
         check_byte = check_byte ^ 8'($urandom_range(1, 255));
      frame = {bytes_in[0], bytes_in[1], bytes_in[2], bytes_in[3], check_byte};
      fault_bit = $urandom_range(0, swfr_pkg::FRAME_BITS - 1);
      for (int i = swfr_pkg::FRAME_BITS - 1; i >= 0; i--) begin
         if (fault == FAULT_BIT_LOW && i == fault_bit) begin
            push_ticks(wait_cap, 1'b0);
            return;
         end
         push_ticks(pick_len(wait_cap - 1), 1'b0);
         push_tick(1'b1);
         push_noise(sample_cap - 1);
         push_tick(frame[i]);
         if (fault == FAULT_BIT_HIGH && i == fault_bit) begin
            push_ticks(wait_cap, 1'b1);
            return;
         end
         push_ticks(pick_len(wait_cap - 1), 1'b1);
         push_tick(1'b0);
      end
   endtask

   task automatic run_reads(int target);
      int first;
      int pick;
      first = line_samples.size();
      while (line_samples.size() - first < target) begin
         pick = $urandom_range(0, 11);
         // half of the reads are clean frames
         play_read(pick < 6 ? FAULT_NONE : fault_type'(pick - 5));
         in_read = 1'b0;
         push_noise($urandom_range(0, 3));
      end
   endtask

   task automatic write_reg(logic [swfr_pkg::CSR_INDEX_W-1:0] idx,
                            logic [swfr_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         swfr_pkg::CSR_SENSOR_TYPE:      cfg.sensor_type = value[0];
         swfr_pkg::CSR_START_LOW_TICKS:  cfg.start_low_ticks = value;
         swfr_pkg::CSR_RELEASE_TICKS:    cfg.release_ticks = value[7:0];
         swfr_pkg::CSR_RESPONSE_LIMIT:   cfg.response_limit = value[7:0];
         swfr_pkg::CSR_BIT_WAIT_LIMIT:   cfg.bit_wait_limit = value[7:0];
         swfr_pkg::CSR_BIT_SAMPLE_DELAY: cfg.bit_sample_delay = value[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // upper bits beyond each narrower register's width carry junk; the start-low count uses all 16
   task automatic apply_settings(logic kind, int low_len, int rel, int resp,
                                 int bit_wait, int delay);
      logic [15:0] junk;
      junk = 16'($urandom);
      write_reg(swfr_pkg::CSR_SENSOR_TYPE, {junk[15:1], kind});
      write_reg(swfr_pkg::CSR_START_LOW_TICKS, 16'(low_len));
      write_reg(swfr_pkg::CSR_RELEASE_TICKS, {junk[7:0], 8'(rel)});
      write_reg(swfr_pkg::CSR_RESPONSE_LIMIT, {junk[15:8], 8'(resp)});
      write_reg(swfr_pkg::CSR_BIT_WAIT_LIMIT, {~junk[7:0], 8'(bit_wait)});
      write_reg(swfr_pkg::CSR_BIT_SAMPLE_DELAY, {~junk[15:8], 8'(delay)});
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (line_samples.size() != 0 || req_tvalid || expected_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      cfg.sensor_type = 1'b0;
      cfg.start_low_ticks = 16'd20000;
      cfg.release_ticks = 8'd20;
      cfg.response_limit = 8'd90;
      cfg.bit_wait_limit = 8'd60;
      cfg.bit_sample_delay = 8'd30;
      rd_phase = RD_IDLE;
      tick_cnt = '0;
      bit_cnt = '0;
      frame_shift = '0;
      status_latched = swfr_pkg::STATUS_OK;
      hum_val = '0;
      temp_val = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: idle ticks, start while busy, no response, response timeouts
      apply_settings(1'b0, 2, 2, 3, 3, 2);
      push_item(1'b0, 1'b0);
      push_item(1'b0, 1'b1);
      push_item(1'b1, 1'b1);
      push_item(1'b1, 1'b0);
      push_ticks(2, 1'b1);
      push_tick(1'b0);
      push_tick(1'b1);
      push_item(1'b1, 1'b0);
      push_ticks(3, 1'b0);
      push_ticks(5, 1'b0);
      push_item(1'b1, 1'b1);
      push_ticks(3, 1'b1);
      push_tick(1'b0);
      push_tick(1'b1);
      push_ticks(4, 1'b1);
      wait_drained();

      // random small settings, both encodings
      for (int p = 0; p < 4; p++) begin
         apply_settings(p < 2 ? 1'(p) : 1'($urandom_range(0, 1)),
                        $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 6),
                        $urandom_range(1, 5), $urandom_range(1, 4));
         idling_on = (p != 2);
         run_reads(60);
         if (p == 2)
            -> stall_kick;
         wait_drained();
      end

      // count registers at their minimum
      apply_settings(1'b1, 1, 1, 1, 1, 1);
      idling_on = 1'b1;
      run_reads(50);
      wait_drained();

      // zero counts act as one, the response limit apart; spare register indexes are ignored
      apply_settings(1'b0, 0, 0, 0, 0, 0);
      write_reg(CSR_SPARE_A, 16'($urandom));
      write_reg(CSR_SPARE_B, 16'($urandom));
      run_reads(50);
      wait_drained();

      // widest 8-bit counts: long response phases at full rate with a receiver hold-off
      apply_settings(1'b1, 30, 255, 255, 255, 255);
      idling_on = 1'b0;
      play_read(FAULT_RESP_HIGH);
      in_read = 1'b0;
      -> stall_kick;
      wait_drained();

      if (mismatches == 0 && expected_readings.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #(8_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: single_wire_sensor_frame_reader_unit.f
+incdir+rtl
rtl/swfr_pkg.sv
rtl/swfr_front.sv
rtl/swfr_queue.sv
rtl/swfr_back.sv
rtl/single_wire_sensor_frame_reader_unit.sv
rtl/swfr_checker.sv
sim/tb_single_wire_sensor_frame_reader_unit.sv
